### src/max_heap_priority_queue_assert.svh
// Assertion macros for the max-heap priority queue.
// No dependencies; expects clk_i and rst_ni in the including scope.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MHPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MHPQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MHPQ_ASSERT(name, prop, msg)
`define MHPQ_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

### src/mhpq_pkg.sv
// Shared constants, codes and types for the max-heap priority queue.
// No dependencies.
package mhpq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = ADDR_W + 1;
  localparam int unsigned DATA_W   = 32;

  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_PEEK   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0]        raddr_a;
    logic [ADDR_W-1:0]        raddr_b;
  } ram_req_t;

endpackage

### src/max_heap_priority_queue.sv
// Max-heap priority queue of signed 32-bit elements: top level.
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_ram and max_heap_priority_queue_assert.svh.
//
// Usage: drive kind_i and element_i with start_i high; the request is taken at a
// clock edge where busy_o is low. kind 0 inserts, 1 removes the maximum, 2 (and 3)
// peeks. Exactly one result per request appears on value_o, count_o, empty_res_o
// and status_o for the single cycle in which done_o is high; it must be captured
// then, as the receiver has no way to hold it.
// Peek, remove on an empty queue, remove of the last element and insert into a
// full queue are answered from idle. An insert climbs one level per read of the
// parent (ST_UP_RD) and compare/write (ST_UP_CMP) until it reaches the root or a
// parent that is not smaller; a remove fetches the last element (ST_DN_LAST),
// then per level reads both children (ST_DN_RD) and compares/writes (ST_DN_CMP)
// until the element lands on a leaf or a compare stops it. Each level costs one
// RAM read and one compare/write on the single heap RAM.
// busy_o is low again in the cycle done_o is high, so a new request may follow.
// Reset clears the element count; heap contents need no clearing since only
// slots below the count are read.
`include "max_heap_priority_queue_assert.svh"
module max_heap_priority_queue
  import mhpq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               kind_i,
  input  logic signed [DATA_W-1:0] element_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] value_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     empty_res_o,
  output logic [1:0]               status_o
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] rdata_a, rdata_b;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .kind_i      (kind_i),
    .element_i   (element_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .value_o     (value_o),
    .count_o     (count_o),
    .empty_res_o (empty_res_o),
    .status_o    (status_o),
    .ram_req_o   (ram_req),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b)
  );

  mhpq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_req.we),
    .waddr_i   (ram_req.waddr),
    .wdata_i   (ram_req.wdata),
    .raddr_a_i (ram_req.raddr_a),
    .raddr_b_i (ram_req.raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  `MHPQ_ASSERT(a_done_not_busy, done_o |-> !busy_o, "result strobed while still busy")
  `MHPQ_ASSERT(a_count_bound, count_o <= CNT_W'(CAPACITY), "count beyond capacity")
  `MHPQ_ASSERT(a_no_idle_write, !busy_o |-> !ram_req.we, "heap write while idle")
  `MHPQ_ASSERT(a_busy_done, (start_i && !busy_o) |=> (busy_o || done_o),
               "accepted request neither in progress nor answered")

endmodule

### src/mhpq_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module mhpq_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### src/mhpq_ctrl.sv
// Sequencer for the heap: sift-up on insert, sift-down on remove, result register.
// Depends on mhpq_pkg; drives the heap RAM through ram_req_t.
module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [1:0]               kind_i,
  input  logic signed [DATA_W-1:0] element_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] value_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     empty_res_o,
  output logic [1:0]               status_o,
  output ram_req_t                 ram_req_o,
  input  logic signed [DATA_W-1:0] rdata_a_i,
  input  logic signed [DATA_W-1:0] rdata_b_i
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_UP_RD   = 3'd1;
  localparam logic [2:0] ST_UP_CMP  = 3'd2;
  localparam logic [2:0] ST_DN_LAST = 3'd3;
  localparam logic [2:0] ST_DN_RD   = 3'd4;
  localparam logic [2:0] ST_DN_CMP  = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [ADDR_W-1:0]        pos_q, pos_d;
  logic signed [DATA_W-1:0] cur_q, cur_d;
  logic signed [DATA_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     right_ok_q, right_ok_d;
  logic                     done_q, done_d;
  logic signed [DATA_W-1:0] res_value_q, res_value_d;
  logic [1:0]               res_status_q, res_status_d;

  logic [ADDR_W-1:0]        parent;
  logic [CNT_W-1:0]         left, right;
  logic                     pick_right;
  logic signed [DATA_W-1:0] best;
  logic [ADDR_W-1:0]        best_idx;
  logic [CNT_W-1:0]         last;

  assign parent     = (pos_q - ADDR_W'(1)) >> 1;
  assign left       = {pos_q, 1'b1};
  assign right      = left + CNT_W'(1);
  assign pick_right = right_ok_q && (rdata_b_i > rdata_a_i);
  assign best       = pick_right ? rdata_b_i : rdata_a_i;
  assign best_idx   = pick_right ? right[ADDR_W-1:0] : left[ADDR_W-1:0];
  assign last       = cnt_q - CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    cur_d        = cur_q;
    root_d       = root_q;
    cnt_d        = cnt_q;
    right_ok_d   = right_ok_q;
    done_d       = 1'b0;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    ram_req_o    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_status_d = STAT_OK;
          case (kind_i)
            KIND_INSERT: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                res_value_d  = root_q;
                res_status_d = STAT_FULL;
                done_d       = 1'b1;
              end else begin
                res_value_d = (cnt_q == '0 || element_i > root_q) ? element_i : root_q;
                cnt_d       = cnt_q + CNT_W'(1);
                pos_d       = cnt_q[ADDR_W-1:0];
                cur_d       = element_i;
                state_d     = ST_UP_RD;
              end
            end
            KIND_REMOVE: begin
              if (cnt_q == '0) begin
                res_value_d  = INT_MIN;
                res_status_d = STAT_EMPTY;
                done_d       = 1'b1;
              end else begin
                res_value_d = root_q;
                cnt_d       = last;
                // last element fetched now, moved to the root after
                ram_req_o.raddr_a = last[ADDR_W-1:0];
                if (last == '0) begin
                  done_d = 1'b1;
                end else begin
                  state_d = ST_DN_LAST;
                end
              end
            end
            default: begin
              if (cnt_q == '0) begin
                res_value_d  = INT_MIN;
                res_status_d = STAT_EMPTY;
              end else begin
                res_value_d = root_q;
              end
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_UP_RD: begin
        if (pos_q == '0) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = pos_q;
          ram_req_o.wdata = cur_q;
          state_d         = ST_IDLE;
          done_d          = 1'b1;
        end else begin
          ram_req_o.raddr_a = parent;
          state_d           = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = pos_q;
        if (cur_q > rdata_a_i) begin
          // parent moves down, keep climbing
          ram_req_o.wdata = rdata_a_i;
          pos_d           = parent;
          state_d         = ST_UP_RD;
        end else begin
          ram_req_o.wdata = cur_q;
          state_d         = ST_IDLE;
          done_d          = 1'b1;
        end
      end

      ST_DN_LAST: begin
        cur_d   = rdata_a_i;
        pos_d   = '0;
        state_d = ST_DN_RD;
      end

      ST_DN_RD: begin
        if (left >= cnt_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = pos_q;
          ram_req_o.wdata = cur_q;
          state_d         = ST_IDLE;
          done_d          = 1'b1;
        end else begin
          ram_req_o.raddr_a = left[ADDR_W-1:0];
          ram_req_o.raddr_b = right[ADDR_W-1:0];
          right_ok_d        = right < cnt_q;
          state_d           = ST_DN_CMP;
        end
      end

      ST_DN_CMP: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = pos_q;
        if (best > cur_q) begin
          ram_req_o.wdata = best;
          pos_d           = best_idx;
          state_d         = ST_DN_RD;
        end else begin
          ram_req_o.wdata = cur_q;
          state_d         = ST_IDLE;
          done_d          = 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // root copy follows every write to the top slot
    if (ram_req_o.we && ram_req_o.waddr == '0) begin
      root_d = ram_req_o.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    cur_q        <= cur_d;
    root_q       <= root_d;
    right_ok_q   <= right_ok_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
  end

  assign busy_o      = state_q != ST_IDLE;
  assign done_o      = done_q;
  assign value_o     = res_value_q;
  assign count_o     = cnt_q;
  assign empty_res_o = cnt_q == '0;
  assign status_o    = res_status_q;

endmodule
